// ----- hw/rtl/ray_box_slab_test_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the ray/box slab test port checker
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_TOP_MACROS_SVH
`define RAY_BOX_SLAB_TEST_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define RBST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define RBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/rbst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types of the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_BITS      = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic       miss;  // origin outside slab on a near-zero axis
    logic [2:0] skip;  // axis direction within epsilon of zero
    logic [2:0] dneg;  // direction negative, per axis
    logic [5:0] neg;   // quotient sign, per lane
    logic [5:0] zero;  // numerator zero, per lane
  } side_t;

endpackage

// ----- hw/rtl/ray_box_slab_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray versus axis-aligned box slab test in signed fixed point, one hit flag
// per item, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_ready | origin_*, dir_*, box_min_*, box_max_*
//  out     | out_valid/out_ready | hit
//  cfg     | cfg_valid/cfg_ready | cfg_data (epsilon)
//
//  One item per cycle while the output is not stalled.
//  The core is six restoring dividers, one quotient bit per stage.
//  rst (synchronous) clears all valid bits and sets epsilon to 1.
//  A stall at the output freezes the whole pipeline; in_ready follows it.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top #(
  parameter int WORD_BITS = rbst_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] origin_x,
  input  logic signed [WORD_BITS-1:0] origin_y,
  input  logic signed [WORD_BITS-1:0] origin_z,
  input  logic signed [WORD_BITS-1:0] dir_x,
  input  logic signed [WORD_BITS-1:0] dir_y,
  input  logic signed [WORD_BITS-1:0] dir_z,
  input  logic signed [WORD_BITS-1:0] box_min_x,
  input  logic signed [WORD_BITS-1:0] box_min_y,
  input  logic signed [WORD_BITS-1:0] box_min_z,
  input  logic signed [WORD_BITS-1:0] box_max_x,
  input  logic signed [WORD_BITS-1:0] box_max_y,
  input  logic signed [WORD_BITS-1:0] box_max_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rbst_pkg::EPS_BITS-1:0] cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int EB = rbst_pkg::EPS_BITS;
  localparam int EW = ((W > EB) ? W : EB) + 1;
  localparam int CW = ((W > EB) ? W : EB) + 2;

  localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};

  logic [EB-1:0] eps;
  logic          adv;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= rbst_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      eps <= cfg_data;
    end
  end

  // whole pipeline moves unless the output holds an untaken item
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [W-1:0] org [3], dirv [3], bmin [3], bmax [3];
  assign org  = '{origin_x, origin_y, origin_z};
  assign dirv = '{dir_x, dir_y, dir_z};
  assign bmin = '{box_min_x, box_min_y, box_min_z};
  assign bmax = '{box_max_x, box_max_y, box_max_z};

  // stage 1: magnitudes, signs and near-zero checks
  logic [W-1:0]    s1_dm [3];
  logic [W-1:0]    s1_nm [6];
  rbst_pkg::side_t s1_side, s1_side_next;
  logic            s1_vld;
  logic [W-1:0]    dm_c [3];
  logic [W-1:0]    nm_c [6];
  logic [W:0]      dl_c [3];
  logic [W:0]      dh_c [3];

  // per axis: direction magnitude, numerator magnitudes and flags
  always_comb begin
    s1_side_next = '0;
    for (int a = 0; a < 3; a++) begin
      s1_side_next.dneg[a] = dirv[a][W-1];
      dm_c[a]     = dirv[a][W-1] ? W'(-dirv[a]) : W'(dirv[a]);
      dl_c[a]     = {bmin[a][W-1], bmin[a]} - {org[a][W-1], org[a]};
      dh_c[a]     = {bmax[a][W-1], bmax[a]} - {org[a][W-1], org[a]};
      nm_c[2*a]   = dl_c[a][W] ? W'(-dl_c[a]) : dl_c[a][W-1:0];
      nm_c[2*a+1] = dh_c[a][W] ? W'(-dh_c[a]) : dh_c[a][W-1:0];
      s1_side_next.skip[a]     = EW'(dm_c[a]) <= EW'(eps);
      s1_side_next.neg[2*a]    = dl_c[a][W] != dirv[a][W-1];
      s1_side_next.neg[2*a+1]  = dh_c[a][W] != dirv[a][W-1];
      s1_side_next.zero[2*a]   = nm_c[2*a] == '0;
      s1_side_next.zero[2*a+1] = nm_c[2*a+1] == '0;
      // origin outside the slab on a near-zero axis
      if (s1_side_next.skip[a] && (org[a] < bmin[a] || bmax[a] < org[a])) begin
        s1_side_next.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dm   <= dm_c;
      s1_nm   <= nm_c;
      s1_side <= s1_side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  // divider lanes: lo and hi time for each axis
  logic [W-1:0] quo [6];
  logic [5:0]   ovf;

  for (genvar l = 0; l < 6; l++) begin : g_lane
    rbst_div #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (s1_nm[l]),
      .den (s1_dm[l/2]),
      .quo (quo[l]),
      .ovf (ovf[l])
    );
  end

  // flags travel beside the divider stages
  rbst_pkg::side_t side_r [W];
  logic [W-1:0]    vld_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= s1_side;
      for (int k = 1; k < W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[W-2:0], s1_vld};
    end
  end

  // stage 2: saturate, sign, swap into entry/exit per axis
  rbst_pkg::side_t     sd;
  logic signed [W-1:0] t_c [6];
  logic signed [W-1:0] tn_c [3], tx_c [3];
  logic signed [W-1:0] s2_tn [3], s2_tx [3];
  logic                s2_miss, s2_vld;

  assign sd = side_r[W-1];

  for (genvar l = 0; l < 6; l++) begin : g_time
    logic [W-1:0] lim, m;
    always_comb begin
      lim = sd.neg[l] ? T_MIN : T_MAX;
      m   = (ovf[l] || quo[l] > lim) ? lim : quo[l];
      if (sd.zero[l]) begin
        t_c[l] = '0;
      end else if (sd.neg[l]) begin
        t_c[l] = -m;
      end else begin
        t_c[l] = m;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_swap
    always_comb begin
      if (sd.skip[a]) begin
        tn_c[a] = T_MIN;
        tx_c[a] = T_MAX;
      end else if (sd.dneg[a]) begin
        tn_c[a] = t_c[2*a+1];
        tx_c[a] = t_c[2*a];
      end else begin
        tn_c[a] = t_c[2*a];
        tx_c[a] = t_c[2*a+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tn   <= tn_c;
      s2_tx   <= tx_c;
      s2_miss <= sd.miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= vld_r[W-1];
    end
  end

  // stage 3: max of entries, min of exits, final compares
  logic signed [W-1:0]  t_enter, t_exit;
  logic signed [CW-1:0] neg_eps;
  logic                 hit_next;

  always_comb begin
    t_enter = s2_tn[0];
    t_exit  = s2_tx[0];
    for (int a = 1; a < 3; a++) begin
      if (s2_tn[a] > t_enter) t_enter = s2_tn[a];
      if (s2_tx[a] < t_exit) t_exit = s2_tx[a];
    end
    neg_eps  = -$signed(CW'(eps));
    hit_next = !s2_miss && (t_enter < t_exit) && !(CW'(t_exit) < neg_eps);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_vld;
    end
  end

endmodule

// ----- hw/rtl/rbst_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider, one quotient bit per stage:
// floor(num * 2^FRAC_BITS / den), low WORD_BITS bits plus an overflow flag.
// ----------------------------------------------------------------------------
module rbst_div #(
  parameter int WORD_BITS = rbst_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  output logic [WORD_BITS-1:0] quo,
  output logic                 ovf
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  logic [W-1:0] rem_r  [W];
  logic [W-1:0] rest_r [W];
  logic [W-1:0] q_r    [W];
  logic [W-1:0] den_r  [W];
  logic [W-1:0] ovf_r;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] rem_i, rest_i, q_i, den_i;
    logic         ovf_i, b;
    logic [W:0]   r2, diff;

    if (k == 0) begin : g_first
      // high part of the shifted numerator is the starting remainder
      assign rem_i  = num >> (W - F);
      assign rest_i = num << F;
      assign q_i    = '0;
      assign den_i  = den;
      assign ovf_i  = (num >> (W - F)) >= den;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign rest_i = rest_r[k-1];
      assign q_i    = q_r[k-1];
      assign den_i  = den_r[k-1];
      assign ovf_i  = ovf_r[k-1];
    end

    // shift in one numerator bit, trial subtract
    always_comb begin
      r2   = {rem_i, rest_i[W-1]};
      b    = r2 >= {1'b0, den_i};
      diff = r2 - {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= b ? diff[W-1:0] : r2[W-1:0];
        rest_r[k] <= rest_i << 1;
        q_r[k]    <= {q_i[W-2:0], b};
        den_r[k]  <= den_i;
        ovf_r[k]  <= ovf_i;
      end
    end
  end

  assign quo = q_r[W-1];
  assign ovf = ovf_r[W-1];

endmodule

// ----- hw/rtl/rbst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks of the slab test block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_top_macros.svh"

module rbst_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit,
  input logic cfg_valid,
  input logic cfg_ready
);

  // a held result item stays offered
  `RBST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // and keeps its value
  `RBST_ASSERT_NEXT(a_hit_stable, clk, rst, out_valid && !out_ready, $stable(hit))
  // an empty output stage never blocks the input
  `RBST_ASSERT_NOW(a_in_free, clk, rst, !out_valid, in_ready)
  // input stalls only behind a stalled output item
  `RBST_ASSERT_NOW(a_in_stall, clk, rst, !in_ready, out_valid && !out_ready)
  // register writes are never refused
  `RBST_ASSERT_NOW(a_cfg_take, clk, rst, cfg_valid, cfg_ready)

endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (.*);

// ----- sim/ray_box_slab_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/box slab test checker
// Watches the input, output and configuration channels of the slab test
// block, predicts the hit flag of every accepted item and compares it with
// the results in order.
// ----------------------------------------------------------------------------
module ray_box_slab_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  input  logic signed [31:0]            dir_x,
  input  logic signed [31:0]            dir_y,
  input  logic signed [31:0]            dir_z,
  input  logic signed [31:0]            box_min_x,
  input  logic signed [31:0]            box_min_y,
  input  logic signed [31:0]            box_min_z,
  input  logic signed [31:0]            box_max_x,
  input  logic signed [31:0]            box_max_y,
  input  logic signed [31:0]            box_max_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          hit,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rbst_pkg::EPS_BITS-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int FRAC = rbst_pkg::FRAC_BITS_DEF;
  localparam longint T_MAX = 64'sd2147483647;
  localparam longint T_MIN = -64'sd2147483648;
  localparam int EXP_DEPTH = 64;

  logic [rbst_pkg::EPS_BITS-1:0] eps_model;
  // ring of expected hit flags, oldest at exp_rd
  logic                          exp_mem [EXP_DEPTH];
  int                            exp_wr, exp_rd;

  // crossing time of one slab plane, fixed point, saturated to the word
  function automatic longint plane_time(longint bound, longint org, longint dmag,
                                        bit dneg);
    longint diff, nmag, lim, q;
    bit     qneg;
    diff = bound - org;
    if (diff == 0) return 0;
    nmag = (diff < 0) ? -diff : diff;
    qneg = (diff < 0) != dneg;
    lim  = qneg ? -T_MIN : T_MAX;
    q    = (nmag <<< FRAC) / dmag;
    if (q > lim) q = lim;
    return qneg ? -q : q;
  endfunction

  // slab test over the three axes
  function automatic logic predict_hit(logic signed [31:0] org [3],
                                       logic signed [31:0] dir [3],
                                       logic signed [31:0] lo [3],
                                       logic signed [31:0] hi [3],
                                       logic [15:0] eps);
    longint t_in, t_out, o, d, dmag, t0, t1, tmp;
    bit     dneg, ok;
    t_in  = T_MIN;
    t_out = T_MAX;
    ok    = 1'b1;
    for (int a = 0; a < 3 && ok; a++) begin
      o    = org[a];
      d    = dir[a];
      dneg = d < 0;
      dmag = dneg ? -d : d;
      if (dmag <= longint'(eps)) begin
        // parallel to the slab: origin must lie inside it
        if (o < longint'(lo[a]) || o > longint'(hi[a])) ok = 1'b0;
        continue;
      end
      t0 = plane_time(lo[a], o, dmag, dneg);
      t1 = plane_time(hi[a], o, dmag, dneg);
      if (dneg) begin
        tmp = t0; t0 = t1; t1 = tmp;
      end
      if (t0 > t_in) t_in = t0;
      if (t1 < t_out) t_out = t1;
      if (t_in >= t_out) ok = 1'b0;
    end
    if (ok && t_out < -longint'(eps)) ok = 1'b0;
    return ok;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic               want;
    if (rst) begin
      eps_model  <= rbst_pkg::EPS_RESET;
      exp_wr = 0;
      exp_rd = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) eps_model <= cfg_data;
      // expectation for each accepted item
      if (in_valid && in_ready) begin
        org = '{origin_x, origin_y, origin_z};
        dir = '{dir_x, dir_y, dir_z};
        lo  = '{box_min_x, box_min_y, box_min_z};
        hi  = '{box_max_x, box_max_y, box_max_z};
        exp_mem[exp_wr % EXP_DEPTH] = predict_hit(org, dir, lo, hi, eps_model);
        exp_wr = exp_wr + 1;
      end
      // compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          $error("result with no item outstanding: hit=%0b", hit);
          fail_count <= fail_count + 1;
        end else begin
          want   = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd = exp_rd + 1;
          if (hit !== want) begin
            $error("field hit: expected %0b, actual %0b", want, hit);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= exp_wr - exp_rd;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/box slab test testbench
// Drives directed corner cases and shaped random rays into the slab test
// block across several epsilon settings, with random gaps and stalls; the
// checker predicts and compares every hit flag.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYC  = 60;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, hit;
  logic cfg_valid, cfg_ready;
  logic [rbst_pkg::EPS_BITS-1:0] cfg_data;
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  int fail_count, pending, idle_cyc;
  bit no_gaps, no_stalls;

  ray_box_slab_test_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(org[0]), .origin_y(org[1]), .origin_z(org[2]),
    .dir_x(dir[0]), .dir_y(dir[1]), .dir_z(dir[2]),
    .box_min_x(lo[0]), .box_min_y(lo[1]), .box_min_z(lo[2]),
    .box_max_x(hi[0]), .box_max_y(hi[1]), .box_max_z(hi[2]),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ray_box_slab_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(org[0]), .origin_y(org[1]), .origin_z(org[2]),
    .dir_x(dir[0]), .dir_y(dir[1]), .dir_z(dir[2]),
    .box_min_x(lo[0]), .box_min_y(lo[1]), .box_min_z(lo[2]),
    .box_max_x(hi[0]), .box_max_y(hi[1]), .box_max_z(hi[2]),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // result side: random stalls after each result, sometimes none
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 63) == 0) no_stalls = !no_stalls;
      n = no_stalls ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_item(logic signed [31:0] o [3], logic signed [31:0] d [3],
                           logic signed [31:0] l [3], logic signed [31:0] h [3]);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 19);
    repeat (n) @(negedge clk);
    org = o; dir = d; lo = l; hi = h;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_eps(logic [15:0] val);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // one random ray: full noise, aimed at the box, or near-parallel axes
  task automatic send_random();
    logic signed [31:0] o [3], d [3], l [3], h [3];
    logic signed [31:0] c, w;
    int mode;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode < 2) begin
        o[a] = $urandom; d[a] = $urandom; l[a] = $urandom; h[a] = $urandom;
      end else begin
        c    = small_val(1 << 22);
        w    = $urandom_range(0, 1 << 20);
        l[a] = c - w;
        h[a] = c + w;
        if ($urandom_range(0, 19) == 0) begin
          l[a] = c + w; h[a] = c - w;
        end
        o[a] = small_val(1 << 23);
        if (mode < 8) d[a] = ((c - o[a]) >>> $urandom_range(0, 6)) + small_val(1 << 14);
        else          d[a] = small_val(4);
        if ($urandom_range(0, 7) == 0) d[a] = -d[a];
      end
    end
    send_item(o, d, l, h);
  endtask

  initial begin
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    rst = 1'b1;
    in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    org = '{0, 0, 0}; dir = '{0, 0, 0}; lo = '{0, 0, 0}; hi = '{0, 0, 0};
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners at reset epsilon
    // all axes parallel, origin inside: hit
    send_item('{0, 0, 0}, '{0, 1, -1}, '{-10, -10, -10}, '{10, 10, 10});
    // parallel axis, origin outside: miss
    send_item('{20, 0, 0}, '{0, 65536, 0}, '{-10, -10, -10}, '{10, 10, 10});
    send_item('{-20, 0, 0}, '{0, 65536, 0}, '{-10, -10, -10}, '{10, 10, 10});
    // straight hit along +x and -x
    send_item('{-65536 * 5, 0, 0}, '{65536, 0, 0}, '{-65536, -65536, -65536},
              '{65536, 65536, 65536});
    send_item('{65536 * 5, 0, 0}, '{-65536, 0, 0}, '{-65536, -65536, -65536},
              '{65536, 65536, 65536});
    // box behind the ray
    send_item('{65536 * 5, 0, 0}, '{65536, 0, 0}, '{-65536, -65536, -65536},
              '{65536, 65536, 65536});
    // origin inside the box, diagonal ray
    send_item('{0, 0, 0}, '{65536, -65536, 32768}, '{-65536, -65536, -65536},
              '{65536, 65536, 65536});
    // inverted box
    send_item('{0, 0, 0}, '{65536, 65536, 65536}, '{65536, 65536, 65536},
              '{-65536, -65536, -65536});
    // zero numerator on a plane
    send_item('{-65536, 0, 0}, '{65536, 65536, 65536}, '{-65536, -65536, -65536},
              '{65536, 65536, 65536});
    // word extremes, saturating quotients
    send_item('{mn, mn, mn}, '{2, 2, 2}, '{mx, mx, mx}, '{mx, mx, mx});
    send_item('{mx, mn, mx}, '{mn, mx, mn}, '{mn, mn, mn}, '{mx, mx, mx});
    send_item('{mn, mx, 0}, '{mx, mn, 2}, '{mn, mn, mn}, '{mx, mx, mx});
    send_item('{mx, mx, mx}, '{-2, -2, -2}, '{mn, mn, mn}, '{mn, mn, mn});
    send_item('{0, 0, 0}, '{mn, mn, mn}, '{mn, mn, mn}, '{mx, mx, mx});
    send_item('{-1, -1, -1}, '{-1, -1, -1}, '{0, 0, 0}, '{0, 0, 0});
    // exit just below zero: epsilon decides
    send_item('{2, 0, 0}, '{65536, 0, 0}, '{-65536, -65536, -65536},
              '{1, 65536, 65536});

    // random phases across epsilon settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_eps(16'd0);
        2: write_eps(16'hffff);
        3: write_eps(16'd1);
        4: write_eps(16'($urandom_range(2, 65534)));
        5: write_eps(16'd3);
        default: ;
      endcase
      for (int i = 0; i < 160; i++) begin
        if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
        send_random();
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
